// ===== rtl/scn_pkg.sv =====
// scn_pkg: shared types and constants for the script number codec
// used by scn_alu, scn_ctrl and script_number_codec_unit; no dependencies
package scn_pkg;

	localparam int MAX_DECODE_BYTES = 8;

	localparam logic [3:0] BC_SAT      = 4'd9;
	localparam logic [3:0] MAX_LEN_RST = 4'd4;

	localparam logic [1:0] KIND_NUMBER     = 2'd0;
	localparam logic [1:0] KIND_BYTE       = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW   = 2'd2;
	localparam logic [1:0] KIND_NONMINIMAL = 2'd3;

	localparam logic [1:0] REG_MAX_LENGTH      = 2'd0;
	localparam logic [1:0] REG_REQUIRE_MINIMAL = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC_FIN,
		ST_ENC_MAG,
		ST_ENC_EMIT,
		ST_ENC_EXTRA
	} state_t;

	typedef struct packed {
		logic [3:0] max_length;
		logic       require_minimal;
	} cfg_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] opnd;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] res;
		logic [31:0] sat;
	} alu_rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] number;
		logic [31:0] number_saturated;
		logic [7:0]  out_byte;
		logic        empty_encoding;
		logic        last;
	} res_t;

endpackage

// ===== rtl/scn_alu.sv =====
// scn_alu: shared 64-bit conditional negate with 32-bit saturation
// depends on scn_pkg
module scn_alu (
	input  scn_pkg::alu_req_t req,
	output scn_pkg::alu_rsp_t rsp
);

	logic [63:0] neg_val;
	logic        neg_big;
	logic        pos_big;

	assign neg_val = 64'd0 - req.opnd;
	assign neg_big = (req.opnd[63:32] != 32'd0) || (req.opnd[31] && (req.opnd[30:0] != 31'd0));
	assign pos_big = (req.opnd[63:31] != 33'd0);

	always_comb begin
		if (req.neg) begin
			rsp.res = neg_val;
			rsp.sat = neg_big ? 32'h8000_0000 : neg_val[31:0];
		end else begin
			rsp.res = req.opnd;
			rsp.sat = pos_big ? 32'h7fff_ffff : req.opnd[31:0];
		end
	end

endmodule

// ===== rtl/scn_ctrl.sv =====
// scn_ctrl: sequencer for decode runs and encode byte emission
// depends on scn_pkg and scn_alu
module scn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  scn_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              in_empty,
	input  logic [63:0]       in_value,
	input  logic              load_ok,
	output logic              res_load,
	output scn_pkg::res_t     res
);

	scn_pkg::state_t   state_q, state_d;
	scn_pkg::alu_req_t alu_req;
	scn_pkg::alu_rsp_t alu_rsp;

	logic [63:0] acc_q;
	logic [3:0]  bc_q;
	logic [7:0]  prev_q;
	logic        sign_q;
	logic [1:0]  kind_q;
	logic [63:0] sh_q;
	logic        neg_q;
	logic        zero_q;

	logic        accept;
	logic [5:0]  pos;
	logic [3:0]  len;
	logic [3:0]  limit;
	logic        ovf;
	logic        nonmin;
	logic        enc_top;

	assign accept = in_valid && in_ready;
	assign pos    = {bc_q[2:0], 3'b000};
	assign len    = (bc_q == scn_pkg::BC_SAT) ? scn_pkg::BC_SAT : bc_q + 4'd1;
	assign limit  = (cfg.max_length < 4'(scn_pkg::MAX_DECODE_BYTES)) ? cfg.max_length
	                : 4'(scn_pkg::MAX_DECODE_BYTES);
	assign ovf    = len > limit;
	assign nonmin = cfg.require_minimal && (in_byte[6:0] == 7'd0)
	                && ((len <= 4'd1) || !prev_q[7]);
	assign enc_top = (sh_q[63:8] == 56'd0);

	always_comb begin
		if (state_q == scn_pkg::ST_DEC_FIN) begin
			alu_req.neg  = sign_q;
			alu_req.opnd = acc_q;
		end else begin
			alu_req.neg  = sh_q[63];
			alu_req.opnd = sh_q;
		end
	end

	scn_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		res_load = 1'b0;
		res      = '0;
		case (state_q)
			scn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode)
						state_d = scn_pkg::ST_ENC_MAG;
					else if (in_empty || in_last)
						state_d = scn_pkg::ST_DEC_FIN;
				end
			end
			scn_pkg::ST_DEC_FIN: begin
				res.kind = kind_q;
				res.last = 1'b1;
				if (kind_q == scn_pkg::KIND_NUMBER) begin
					res.number           = alu_rsp.res;
					res.number_saturated = alu_rsp.sat;
				end
				if (load_ok) begin
					res_load = 1'b1;
					state_d  = scn_pkg::ST_IDLE;
				end
			end
			scn_pkg::ST_ENC_MAG: begin
				state_d = scn_pkg::ST_ENC_EMIT;
			end
			scn_pkg::ST_ENC_EMIT: begin
				res.kind = scn_pkg::KIND_BYTE;
				if (zero_q) begin
					res.empty_encoding = 1'b1;
					res.last           = 1'b1;
				end else if (!enc_top || sh_q[7]) begin
					res.out_byte = sh_q[7:0];
				end else begin
					res.out_byte = {neg_q | sh_q[7], sh_q[6:0]};
					res.last     = 1'b1;
				end
				if (load_ok) begin
					res_load = 1'b1;
					if (zero_q || (enc_top && !sh_q[7]))
						state_d = scn_pkg::ST_IDLE;
					else if (enc_top)
						state_d = scn_pkg::ST_ENC_EXTRA;
				end
			end
			scn_pkg::ST_ENC_EXTRA: begin
				res.kind     = scn_pkg::KIND_BYTE;
				res.out_byte = {neg_q, 7'd0};
				res.last     = 1'b1;
				if (load_ok) begin
					res_load = 1'b1;
					state_d  = scn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scn_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decode run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bc_q   <= '0;
			prev_q <= '0;
			sign_q <= 1'b0;
			kind_q <= scn_pkg::KIND_NUMBER;
		end else if (accept && !in_mode) begin
			if (in_empty) begin
				acc_q  <= '0;
				sign_q <= 1'b0;
				kind_q <= scn_pkg::KIND_NUMBER;
			end else if (!in_last) begin
				if (!bc_q[3])
					acc_q[pos +: 8] <= acc_q[pos +: 8] | in_byte;
				prev_q <= in_byte;
				if (bc_q != scn_pkg::BC_SAT)
					bc_q <= bc_q + 4'd1;
			end else begin
				if (!bc_q[3])
					acc_q[pos +: 8] <= acc_q[pos +: 8] | {1'b0, in_byte[6:0]};
				sign_q <= in_byte[7];
				if (ovf)
					kind_q <= scn_pkg::KIND_OVERFLOW;
				else if (nonmin)
					kind_q <= scn_pkg::KIND_NONMINIMAL;
				else
					kind_q <= scn_pkg::KIND_NUMBER;
			end
		end else if (state_q == scn_pkg::ST_DEC_FIN && load_ok) begin
			acc_q  <= '0;
			bc_q   <= '0;
			prev_q <= '0;
			sign_q <= 1'b0;
		end
	end

	// encode working register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			zero_q <= 1'b0;
		end else if (state_q == scn_pkg::ST_ENC_MAG) begin
			neg_q  <= sh_q[63];
			zero_q <= (sh_q == 64'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_mode)
			sh_q <= in_value;
		else if (state_q == scn_pkg::ST_ENC_MAG)
			sh_q <= alu_rsp.res;
		else if (state_q == scn_pkg::ST_ENC_EMIT && load_ok)
			sh_q <= {8'd0, sh_q[63:8]};
	end

`ifndef SYNTHESIS
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> state_q != scn_pkg::ST_IDLE)
		else $error("result loaded while idle");

	a_mag_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scn_pkg::ST_ENC_MAG |=> state_q == scn_pkg::ST_ENC_EMIT)
		else $error("encode magnitude step not followed by emission");

	a_bc_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= scn_pkg::BC_SAT)
		else $error("byte count beyond saturation");

	a_extra_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scn_pkg::ST_ENC_EXTRA && res_load) |=> state_q == scn_pkg::ST_IDLE)
		else $error("sign byte did not end the encode run");
`endif

endmodule

// ===== rtl/script_number_codec_unit.sv =====
// script_number_codec_unit: decode bytes at 1 per cycle while idle; a last or empty byte
// enters a finish step; encode of a value runs a magnitude step, then emits n result
// beats (1..9), limited by the single sequencer and shared negate unit; input is stalled
// while a run is emitted; one output register parts the result side, and a full one
// held by m_axis_tready low holds the sequencer; arst_n resets the sequencer, decode run
// state, output valid and config (max_length 4, require_minimal 1); needs scn_pkg, scn_ctrl
module script_number_codec_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [3:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,   // data_byte[7:0], value_in[71:8]
	input  logic [1:0]   s_axis_tuser,   // mode[0], empty_number[1]
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // number[63:0], number_saturated[95:64], out_byte[103:96]
	output logic [2:0]   m_axis_tuser,   // result_kind[1:0], empty_encoding[2]
	output logic         m_axis_tlast
);

	scn_pkg::cfg_t cfg_q;
	scn_pkg::res_t res;
	scn_pkg::res_t out_q;
	logic          out_valid_q;
	logic          load_ok;
	logic          res_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length      <= scn_pkg::MAX_LEN_RST;
			cfg_q.require_minimal <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				scn_pkg::REG_MAX_LENGTH:      cfg_q.max_length      <= cfg_data;
				scn_pkg::REG_REQUIRE_MINIMAL: cfg_q.require_minimal <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign load_ok = !out_valid_q || m_axis_tready;

	scn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tuser[0]),
		.in_byte  (s_axis_tdata[7:0]),
		.in_last  (s_axis_tlast),
		.in_empty (s_axis_tuser[1]),
		.in_value (s_axis_tdata[71:8]),
		.load_ok  (load_ok),
		.res_load (res_load),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.out_byte, out_q.number_saturated, out_q.number};
	assign m_axis_tuser  = {out_q.empty_encoding, out_q.kind};
	assign m_axis_tlast  = out_q.last;

endmodule
